// ===== src/lbq_pkg.sv =====
// Package for the linked-buffer queue manager: sizes, codes, item types and helpers.
package lbq_pkg;

    localparam int BUFFER_COUNT = 32;
    localparam int QUEUE_COUNT  = 32;

    localparam int LINK_W = $clog2(BUFFER_COUNT + 1);
    localparam int BUF_AW = $clog2(BUFFER_COUNT);
    localparam int QUE_AW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int HQ_W   = 2 * LINK_W;

    localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(BUFFER_COUNT);
    localparam logic [LINK_W-1:0] TOP_LINK  = LINK_W'(BUFFER_COUNT - 1);

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_TAKE    = 2'd1;
    localparam logic [1:0] FUNC_APPEND  = 2'd2;
    localparam logic [1:0] FUNC_RELEASE = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [4:0] queue_id;
        logic [4:0] buffer_id;
    } t_in_item;

    typedef struct packed {
        logic [4:0] buffer_out;
        logic       got_buffer;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_done;

    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] waddr;
        logic [LINK_W-1:0] wdata;
        logic              re;
        logic [BUF_AW-1:0] raddr;
    } t_lk_req;

    typedef struct packed {
        logic              we;
        logic [QUE_AW-1:0] waddr;
        logic [HQ_W-1:0]   wdata;
        logic              re;
        logic [QUE_AW-1:0] raddr;
    } t_hq_req;

    function automatic logic is_buf(input logic [LINK_W-1:0] l);
        return 32'(l) < BUFFER_COUNT;
    endfunction

    function automatic logic buf_fits(input logic [4:0] b);
        return 32'(b) < BUFFER_COUNT;
    endfunction

    function automatic logic queue_fits(input logic [4:0] q);
        return 32'(q) < QUEUE_COUNT;
    endfunction

    function automatic logic [QUE_AW-1:0] to_qaddr(input logic [4:0] q);
        logic [6:0] qx;
        qx = 7'(q);
        return qx[QUE_AW-1:0];
    endfunction

    function automatic logic [BUF_AW-1:0] to_baddr(input logic [4:0] b);
        logic [6:0] bx;
        bx = 7'(b);
        return bx[BUF_AW-1:0];
    endfunction

    function automatic logic [LINK_W-1:0] buf_to_link(input logic [4:0] b);
        logic [7:0] bx;
        bx = 8'(b);
        return bx[LINK_W-1:0];
    endfunction

    function automatic logic [BUF_AW-1:0] link_to_addr(input logic [LINK_W-1:0] l);
        return l[BUF_AW-1:0];
    endfunction

    function automatic logic [4:0] link_low5(input logic [LINK_W-1:0] l);
        logic [7:0] lx;
        lx = 8'(l);
        return lx[4:0];
    endfunction

    // Power-up chain: each buffer links to the one below, buffer 0 ends the list.
    function automatic logic [LINK_W-1:0] link_reset(input logic [BUF_AW-1:0] a);
        return (a == '0) ? NIL_LINK : LINK_W'(a - BUF_AW'(1));
    endfunction

endpackage

// ===== src/lbq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lbq_ctrl.sv =====
// Operation sequencer: free-list head, entry valid bits and read-modify-write of both RAMs.
module lbq_ctrl import lbq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  t_in_item          i_in_data,
    output logic              o_in_stall,
    input  logic              i_res_pend,
    output t_lk_req           o_lk_req,
    input  logic [LINK_W-1:0] i_lk_rdata,
    output t_hq_req           o_hq_req,
    input  logic [HQ_W-1:0]   i_hq_rdata,
    output t_done             o_done
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;
    localparam logic [2:0] S_TAKE1 = 3'd2;
    localparam logic [2:0] S_TAKE2 = 3'd3;
    localparam logic [2:0] S_APP1  = 3'd4;
    localparam logic [2:0] S_APP2  = 3'd5;

    logic [2:0]              r_state, n_state;
    logic [LINK_W-1:0]       r_free_head, n_free_head;
    t_in_item                r_op;
    logic [LINK_W-1:0]       r_head, n_head;
    logic [LINK_W-1:0]       r_tail, n_tail;
    logic [BUFFER_COUNT-1:0] r_lk_vld;
    logic [QUEUE_COUNT-1:0]  r_hq_vld;
    logic                    r_lk_rvld;
    logic [BUF_AW-1:0]       r_lk_raddr;
    logic                    r_hq_rvld;

    logic              accept;
    logic [LINK_W-1:0] lk_val;
    logic [LINK_W-1:0] hq_head;
    logic [LINK_W-1:0] hq_tail;
    logic [LINK_W-1:0] op_buf;
    logic [QUE_AW-1:0] op_q;

    assign o_in_stall = (r_state != S_IDLE) || i_res_pend;
    assign accept     = i_in_valid && !o_in_stall;

    // Entries never written read as their power-up value.
    assign lk_val  = r_lk_rvld ? i_lk_rdata : link_reset(r_lk_raddr);
    assign hq_head = r_hq_rvld ? i_hq_rdata[HQ_W-1:LINK_W] : NIL_LINK;
    assign hq_tail = r_hq_rvld ? i_hq_rdata[LINK_W-1:0] : NIL_LINK;
    assign op_buf  = buf_to_link(r_op.buffer_id);
    assign op_q    = to_qaddr(r_op.queue_id);

    always_comb begin
        n_state     = r_state;
        n_free_head = r_free_head;
        n_head      = r_head;
        n_tail      = r_tail;
        o_lk_req    = '0;
        o_hq_req    = '0;
        o_done      = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_data.func)
                        FUNC_ALLOC: begin
                            if (is_buf(r_free_head)) begin
                                o_lk_req.re    = 1'b1;
                                o_lk_req.raddr = link_to_addr(r_free_head);
                                n_state        = S_ALLOC;
                            end else begin
                                o_done.valid = 1'b1;
                            end
                        end
                        FUNC_TAKE: begin
                            if (queue_fits(i_in_data.queue_id)) begin
                                o_hq_req.re    = 1'b1;
                                o_hq_req.raddr = to_qaddr(i_in_data.queue_id);
                                n_state        = S_TAKE1;
                            end else begin
                                o_done.valid = 1'b1;
                            end
                        end
                        FUNC_APPEND: begin
                            if (queue_fits(i_in_data.queue_id) &&
                                buf_fits(i_in_data.buffer_id)) begin
                                o_hq_req.re    = 1'b1;
                                o_hq_req.raddr = to_qaddr(i_in_data.queue_id);
                                n_state        = S_APP1;
                            end else begin
                                o_done.valid = 1'b1;
                            end
                        end
                        default: begin
                            // release: push onto the front of the free list
                            o_done.valid = 1'b1;
                            if (buf_fits(i_in_data.buffer_id)) begin
                                o_lk_req.we            = 1'b1;
                                o_lk_req.waddr         = to_baddr(i_in_data.buffer_id);
                                o_lk_req.wdata         = r_free_head;
                                n_free_head            = buf_to_link(i_in_data.buffer_id);
                                o_done.item.got_buffer = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                n_free_head            = lk_val;
                o_done.valid           = 1'b1;
                o_done.item.buffer_out = link_low5(r_free_head);
                o_done.item.got_buffer = 1'b1;
                n_state                = S_IDLE;
            end
            S_TAKE1: begin
                if (is_buf(hq_head)) begin
                    o_lk_req.re    = 1'b1;
                    o_lk_req.raddr = link_to_addr(hq_head);
                    n_head         = hq_head;
                    n_tail         = hq_tail;
                    n_state        = S_TAKE2;
                end else begin
                    o_hq_req.we    = 1'b1;
                    o_hq_req.waddr = op_q;
                    o_hq_req.wdata = {NIL_LINK, NIL_LINK};
                    o_done.valid   = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_TAKE2: begin
                o_hq_req.we            = 1'b1;
                o_hq_req.waddr         = op_q;
                o_hq_req.wdata         = {lk_val, is_buf(lk_val) ? r_tail : NIL_LINK};
                o_done.valid           = 1'b1;
                o_done.item.buffer_out = link_low5(r_head);
                o_done.item.got_buffer = 1'b1;
                n_state                = S_IDLE;
            end
            S_APP1: begin
                o_lk_req.we    = 1'b1;
                o_lk_req.waddr = to_baddr(r_op.buffer_id);
                o_lk_req.wdata = NIL_LINK;
                o_hq_req.we    = 1'b1;
                o_hq_req.waddr = op_q;
                if (!is_buf(hq_head) || !is_buf(hq_tail)) begin
                    o_hq_req.wdata         = {op_buf, op_buf};
                    o_done.valid           = 1'b1;
                    o_done.item.got_buffer = 1'b1;
                    n_state                = S_IDLE;
                end else begin
                    o_hq_req.wdata = {hq_head, op_buf};
                    n_tail         = hq_tail;
                    n_state        = S_APP2;
                end
            end
            S_APP2: begin
                o_lk_req.we            = 1'b1;
                o_lk_req.waddr         = link_to_addr(r_tail);
                o_lk_req.wdata         = op_buf;
                o_done.valid           = 1'b1;
                o_done.item.got_buffer = 1'b1;
                n_state                = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= TOP_LINK;
            r_lk_vld    <= '0;
            r_hq_vld    <= '0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            if (o_lk_req.we) begin
                r_lk_vld[o_lk_req.waddr] <= 1'b1;
            end
            if (o_hq_req.we) begin
                r_hq_vld[o_hq_req.waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_in_data;
        end
        r_head     <= n_head;
        r_tail     <= n_tail;
        r_lk_rvld  <= r_lk_vld[o_lk_req.raddr];
        r_lk_raddr <= o_lk_req.raddr;
        r_hq_rvld  <= r_hq_vld[o_hq_req.raddr];
    end

endmodule

// ===== src/linked_buffer_queue_manager.sv =====
// Top level of the linked-buffer queue manager: RAMs, sequencer and result register.
//
// Manages a pool of BUFFER_COUNT buffers kept as linked lists: one free list
// and QUEUE_COUNT FIFO queues. Each input item carries func (allocate, take,
// append, release), queue_id and buffer_id; each item yields exactly one
// result item with buffer_out and got_buffer, in order.
//
// Channels: valid/stall on both sides. An item moves at a clock edge with
// valid high and stall low. o_in_stall is high while an item is being
// worked on, and while a finished result cannot reach the output register.
//
// Steps from acceptance to the result register, with the output free:
// release finishes in idle; allocate reads the link RAM and finishes in
// S_ALLOC (in idle on an empty free list); append finishes in S_APP1, or
// in S_APP2 when the queue already holds buffers; take reads the head/tail
// RAM, then the link RAM, and finishes in S_TAKE2 (in S_TAKE1 on an empty
// queue). The next item is taken only once the sequencer is back in idle.
//
// Reset (synchronous, active low) puts the whole pool on the free list,
// highest buffer first, and empties every queue at once: per-entry valid
// bits stand in for the power-up RAM contents, so no clearing pass runs.
// A stalled receiver holds the result in the output register; one more
// result waits in a holding register, and input stalls behind it.
module linked_buffer_queue_manager import lbq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_lk_req           lk_req;
    t_hq_req           hq_req;
    logic [LINK_W-1:0] lk_rdata;
    logic [HQ_W-1:0]   hq_rdata;
    t_done             done;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out_data, n_out_data;
    logic      r_pend, n_pend;
    t_out_item r_res, n_res;
    logic      slot_free;

    // Next-link per buffer.
    lbq_ram #(
        .WIDTH (LINK_W),
        .DEPTH (BUFFER_COUNT)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_req.we),
        .i_waddr (lk_req.waddr),
        .i_wdata (lk_req.wdata),
        .i_re    (lk_req.re),
        .i_raddr (lk_req.raddr),
        .o_rdata (lk_rdata)
    );

    // Head and tail pointer pair per queue.
    lbq_ram #(
        .WIDTH (HQ_W),
        .DEPTH (QUEUE_COUNT)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (hq_req.we),
        .i_waddr (hq_req.waddr),
        .i_wdata (hq_req.wdata),
        .i_re    (hq_req.re),
        .i_raddr (hq_req.raddr),
        .o_rdata (hq_rdata)
    );

    lbq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_res_pend (r_pend),
        .o_lk_req   (lk_req),
        .i_lk_rdata (lk_rdata),
        .o_hq_req   (hq_req),
        .i_hq_rdata (hq_rdata),
        .o_done     (done)
    );

    // The output register can take a new item when empty or being drained.
    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        n_pend      = r_pend;
        n_res       = r_res;
        // drain the holding register first
        if (r_pend && slot_free) begin
            n_out_valid = 1'b1;
            n_out_data  = r_res;
            n_pend      = 1'b0;
        end
        // a finished item goes straight out when possible, else park it
        if (done.valid) begin
            if (slot_free && !r_pend) begin
                n_out_valid = 1'b1;
                n_out_data  = done.item;
            end else begin
                n_pend = 1'b1;
                n_res  = done.item;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_res      <= n_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== src/lbq_checker.sv =====
// Port-level checks for the linked-buffer queue manager, bound to the top level.
module lbq_checker import lbq_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input t_in_item  i_in_data,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // A release into a free output shows a successful result next cycle.
    a_release_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.func == FUNC_RELEASE &&
        32'(i_in_data.buffer_id) < BUFFER_COUNT && (!o_out_valid || !i_out_stall)
        |=> o_out_valid && o_out_data.got_buffer && o_out_data.buffer_out == 5'd0)
        else $error("release result missing or wrong");

    // A failed result reports buffer 0.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && !o_out_data.got_buffer |-> o_out_data.buffer_out == 5'd0)
        else $error("failed result carries a buffer index");

endmodule

bind linked_buffer_queue_manager lbq_checker u_checker (.*);

// ===== bench/tb_linked_buffer_queue_manager.sv =====
// Self-checking testbench for the linked-buffer queue manager.
`timescale 1ns / 100ps

module tb_linked_buffer_queue_manager;
    import lbq_pkg::*;

    localparam int NUM_SCRIPT   = 25;
    localparam int NUM_RANDOM   = 700;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 10;

    typedef logic [LINK_W-1:0] t_link;

    // One row of the opening script: the item, and the result typed in where
    // it is obvious; rows with typed low take the predicted result instead.
    typedef struct packed {
        t_in_item  op;
        logic      typed;
        t_out_item want;
    } t_script_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    // Shadow copy of the linked lists: pool (free list) head, per-queue head
    // and tail, and one next-link per buffer. NIL_LINK ends every list.
    t_link pool_head;
    t_link q_first [QUEUE_COUNT];
    t_link q_last  [QUEUE_COUNT];
    t_link link_of [BUFFER_COUNT];

    t_out_item   owed_replies [$];   // results still due, oldest first
    logic [4:0]  in_hand      [$];   // buffers popped and not yet handed back
    int          error_count = 0;
    int          cycle_count = 0;
    bit          calm        = 1'b0; // no gaps and no stalls while set

    // Opening script. Covers: the top buffer first after reset, a double
    // insertion that cuts the free chain short, allocate on an empty free list,
    // take on an empty queue, buffer 0 handed out with got_buffer high, queue
    // and buffer 31, and alternating bit patterns. Out-of-range queue and buffer
    // indexes cannot be formed with the 5-bit fields at the default sizes.
    t_script_row opening_script [NUM_SCRIPT] = '{
        {FUNC_ALLOC,   5'd0,  5'd0,  1'b1, 5'd31, 1'b1},
        {FUNC_APPEND,  5'd5,  5'd30, 1'b1, 5'd0,  1'b1},
        {FUNC_ALLOC,   5'd0,  5'd0,  1'b1, 5'd30, 1'b1},
        {FUNC_ALLOC,   5'd0,  5'd0,  1'b1, 5'd0,  1'b0},
        {FUNC_TAKE,    5'd5,  5'd0,  1'b1, 5'd30, 1'b1},
        {FUNC_TAKE,    5'd5,  5'd0,  1'b1, 5'd0,  1'b0},
        {FUNC_TAKE,    5'd31, 5'd31, 1'b1, 5'd0,  1'b0},
        {FUNC_RELEASE, 5'd31, 5'd31, 1'b1, 5'd0,  1'b1},
        {FUNC_RELEASE, 5'd0,  5'd0,  1'b1, 5'd0,  1'b1},
        {FUNC_ALLOC,   5'd0,  5'd0,  1'b1, 5'd0,  1'b1},
        {FUNC_ALLOC,   5'd0,  5'd0,  1'b1, 5'd31, 1'b1},
        {FUNC_ALLOC,   5'd0,  5'd0,  1'b1, 5'd0,  1'b0},
        {FUNC_APPEND,  5'd31, 5'd0,  1'b0, 5'd0,  1'b0},
        {FUNC_APPEND,  5'd31, 5'd31, 1'b0, 5'd0,  1'b0},
        {FUNC_APPEND,  5'd31, 5'd17, 1'b0, 5'd0,  1'b0},
        {FUNC_TAKE,    5'd31, 5'd0,  1'b0, 5'd0,  1'b0},
        {FUNC_RELEASE, 5'd21, 5'd10, 1'b0, 5'd0,  1'b0},
        {FUNC_APPEND,  5'd10, 5'd21, 1'b0, 5'd0,  1'b0},
        {FUNC_TAKE,    5'd31, 5'd0,  1'b0, 5'd0,  1'b0},
        {FUNC_TAKE,    5'd31, 5'd0,  1'b0, 5'd0,  1'b0},
        {FUNC_TAKE,    5'd31, 5'd0,  1'b0, 5'd0,  1'b0},
        {FUNC_APPEND,  5'd0,  5'd31, 1'b0, 5'd0,  1'b0},
        {FUNC_TAKE,    5'd0,  5'd0,  1'b0, 5'd0,  1'b0},
        {FUNC_ALLOC,   5'd0,  5'd0,  1'b0, 5'd0,  1'b0},
        {FUNC_TAKE,    5'd10, 5'd21, 1'b0, 5'd0,  1'b0}
    };

    linked_buffer_queue_manager u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Apply one operation to the shadow lists and return the result it gives.
    function automatic t_out_item apply_buffer_op(input t_in_item it);
        t_out_item res;
        t_link     popped;
        int        q;
        int        b;
        res    = '0;
        popped = NIL_LINK;
        q      = it.queue_id;
        b      = it.buffer_id;
        case (it.func)
            FUNC_ALLOC: begin
                popped    = pool_head;
                pool_head = (popped < NIL_LINK) ? link_of[popped] : NIL_LINK;
            end
            FUNC_TAKE: begin
                if (q < QUEUE_COUNT) begin
                    popped     = q_first[q];
                    q_first[q] = (popped < NIL_LINK) ? link_of[popped] : NIL_LINK;
                    // drop the tail once the queue runs dry
                    if (q_first[q] >= NIL_LINK) begin
                        q_last[q] = NIL_LINK;
                    end
                end
            end
            FUNC_APPEND: begin
                if (q < QUEUE_COUNT && b < BUFFER_COUNT) begin
                    link_of[b] = NIL_LINK;
                    if (q_first[q] >= NIL_LINK || q_last[q] >= NIL_LINK) begin
                        q_first[q] = t_link'(b);
                    end else begin
                        link_of[q_last[q]] = t_link'(b);
                    end
                    q_last[q]      = t_link'(b);
                    res.got_buffer = 1'b1;
                end
            end
            default: begin
                // release
                if (b < BUFFER_COUNT) begin
                    link_of[b]     = pool_head;
                    pool_head      = t_link'(b);
                    res.got_buffer = 1'b1;
                end
            end
        endcase
        // only the two pops report a buffer index
        if (popped < NIL_LINK) begin
            res.got_buffer = 1'b1;
            res.buffer_out = popped[4:0];
        end
        return res;
    endfunction

    // Idle length for either side: mostly none, often a few cycles, rarely long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Build a random item. Most items follow buffer ownership: allocate or take
    // a buffer, then append it to a queue or release it. The mix shifts every
    // 64 items between draining the pool, churning the queues and handing
    // buffers back, so empty lists and long queues both come up often.
    // The rest is noise with every field free, double insertions included.
    function automatic t_in_item make_random_item(input int n);
        t_in_item it;
        int       roll;
        int       pick;
        int       cut_alloc;
        int       cut_append;
        int       cut_take;
        it.func      = FUNC_ALLOC;
        it.queue_id  = 5'($urandom_range(0, 31));
        it.buffer_id = 5'($urandom_range(0, 31));
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            it.func = 2'($urandom_range(0, 3));
            return it;
        end
        case ((n / 64) % 3)
            0:       begin cut_alloc = 60; cut_append = 80; cut_take = 90; end
            1:       begin cut_alloc = 25; cut_append = 50; cut_take = 75; end
            default: begin cut_alloc = 10; cut_append = 30; cut_take = 60; end
        endcase
        // keep most traffic on a few queues so they grow deep
        if ($urandom_range(0, 99) < 80) begin
            it.queue_id = 5'($urandom_range(0, 3));
        end
        roll = $urandom_range(0, 99);
        if (roll < cut_alloc) begin
            it.func = FUNC_ALLOC;
        end else if (roll < cut_append) begin
            it.func = FUNC_APPEND;
        end else if (roll < cut_take) begin
            it.func = FUNC_TAKE;
        end else begin
            it.func = FUNC_RELEASE;
        end
        if (it.func == FUNC_APPEND || it.func == FUNC_RELEASE) begin
            if (in_hand.size() == 0) begin
                it.func = roll[0] ? FUNC_ALLOC : FUNC_TAKE;
            end else begin
                pick         = $urandom_range(0, in_hand.size() - 1);
                it.buffer_id = in_hand[pick];
                in_hand.delete(pick);
            end
        end
        return it;
    endfunction

    task automatic log_error(input string what, input int want, input int seen);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch on %s: expected %0d, actual %0d",
                     $time, what, want, seen);
        end
    endtask

    // Sender: drive items at the falling edge, hold each until it is accepted
    // at a rising edge, and predict its result at that same edge.
    initial begin : drive_items
        t_in_item  item;
        t_out_item predicted;
        int        gap;
        for (int i = 0; i < BUFFER_COUNT; i++) begin
            link_of[i] = (i == 0) ? NIL_LINK : t_link'(i - 1);
        end
        pool_head = TOP_LINK;
        for (int q = 0; q < QUEUE_COUNT; q++) begin
            q_first[q] = NIL_LINK;
            q_last[q]  = NIL_LINK;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int n = 0; n < NUM_SCRIPT + NUM_RANDOM; n++) begin
            // every sixth stretch of 40 items runs with no idling at all
            calm = ((n / 40) % 6) == 5;
            if (n < NUM_SCRIPT) begin
                item = opening_script[n].op;
            end else begin
                item = make_random_item(n - NUM_SCRIPT);
            end
            gap = pick_gap();
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_data  <= item;
            do @(posedge i_clk); while (o_in_stall);

            predicted = apply_buffer_op(item);
            if ((item.func == FUNC_ALLOC || item.func == FUNC_TAKE) && predicted.got_buffer) begin
                in_hand.push_back(predicted.buffer_out);
            end
            if (n < NUM_SCRIPT && opening_script[n].typed) begin
                owed_replies.push_back(opening_script[n].want);
            end else begin
                owed_replies.push_back(predicted);
            end
            @(negedge i_clk);
        end
        i_in_valid <= 1'b0;
        calm = 1'b0;

        // wait for every owed result, then watch a few cycles for strays
        while (owed_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Receiver: raise stall in runs of random length between short open windows.
    initial begin : stall_receiver
        int run;
        @(negedge i_clk);
        forever begin
            run = pick_gap();
            if (run > 0) begin
                i_out_stall <= 1'b1;
                repeat (run) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    end

    // Compare each accepted result with the oldest owed one, field by field.
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_replies.size() == 0) begin
                log_error("unowed result buffer_out", -1, o_out_data.buffer_out);
            end else begin
                want = owed_replies.pop_front();
                if (o_out_data.buffer_out !== want.buffer_out) begin
                    log_error("buffer_out", want.buffer_out, o_out_data.buffer_out);
                end
                if (o_out_data.got_buffer !== want.got_buffer) begin
                    log_error("got_buffer", want.got_buffer, o_out_data.got_buffer);
                end
            end
        end
    end

    // Hard stop if the run hangs.
    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lbq_pkg.sv
src/lbq_ram.sv
src/lbq_ctrl.sv
src/linked_buffer_queue_manager.sv
src/lbq_checker.sv
bench/tb_linked_buffer_queue_manager.sv
